// File: rtl/router_tally_loop_resolver_assert.svh
// Assertion macros shared by the router tally checker.
`ifndef ROUTER_TALLY_LOOP_RESOLVER_ASSERT_SVH
`define ROUTER_TALLY_LOOP_RESOLVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTLR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("router tally assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RTLR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("router tally assertion failed");

`endif

// File: rtl/rtlr_pkg.sv
`timescale 1ns / 1ps
// Package with the types, constants and codes of the router tally loop resolver.
package rtlr_pkg;

    localparam int ID_W            = 10;
    localparam int CNT_W           = 32;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int MAX_HOPS_DEF    = 10;

    localparam logic [1:0] CMD_STORE      = 2'd0;
    localparam logic [1:0] CMD_SET_SOURCE = 2'd1;
    localparam logic [1:0] CMD_READ       = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_DEST = 3'd0;

    typedef logic [ID_W-1:0] id_t;

    typedef struct packed {
        logic [1:0] command;
        id_t        destination;
        id_t        source;
        logic       is_looped;
        id_t        feeding_destination;
    } req_word_t;

    typedef struct packed {
        logic             accepted;
        id_t              routed_source;
        id_t              resolved_source;
        id_t              reentrant_source;
        logic             loop_breakout;
        logic [CNT_W-1:0] route_count;
    } rsp_word_t;

    typedef struct packed {
        id_t routed;
        id_t resolved;
        id_t reentrant;
    } dest_entry_t;

    typedef struct packed {
        logic looped;
        id_t  feed;
    } src_entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_APPLY,
        ST_HOP_FEED,
        ST_HOP_DEST,
        ST_FINISH,
        ST_DONE
    } state_t;

endpackage

// File: rtl/rtlr_req_if.sv
`timescale 1ns / 1ps
// Request channel interface carrying one command word per handshake.
interface rtlr_req_if;
    logic                  valid;
    logic                  ready;
    rtlr_pkg::req_word_t   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/rtlr_rsp_if.sv
`timescale 1ns / 1ps
// Response channel interface carrying one result word per handshake.
interface rtlr_rsp_if;
    logic                  valid;
    logic                  ready;
    rtlr_pkg::rsp_word_t   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/rtlr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
module rtlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/router_tally_loop_resolver.sv
`timescale 1ns / 1ps
// Top level of the router tally loop resolver: tables in two RAMs and a sequencer.
//
//   channel   dir   handshake          word
//   req       in    valid / ready      command, destination, source, looped, feed
//   rsp       out   valid / ready      accepted, sources, breakout, route count
//   apb       in    psel / penable     max_destination register at byte 0
//
// One word is in work at a time. Set-source, read and any rejected word pass through the
// lookup, apply and done states; a store adds a walk of hops and a finish state, and the
// walk breaks out after ten hops, each hop being a read of the source RAM followed by a
// read of the destination RAM.
// After reset a clearing pass over all TABLE_DEPTH entries zeroes both RAMs; no word is
// accepted until it ends. A stalled response holds in the output register until taken.
module router_tally_loop_resolver #(
    parameter int TABLE_DEPTH = rtlr_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_HOPS    = rtlr_pkg::MAX_HOPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rtlr_req_if.sink                          req,
    rtlr_rsp_if.source                        rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rtlr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [rtlr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [rtlr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int HOP_W  = $clog2(MAX_HOPS + 1);
    localparam int CMP_W  = ((ADDR_W > rtlr_pkg::ID_W) ? ADDR_W : rtlr_pkg::ID_W) + 1;
    localparam logic [CMP_W-1:0]  DEPTH_C   = CMP_W'(TABLE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [HOP_W-1:0]  LAST_HOP  = HOP_W'(MAX_HOPS - 1);
    localparam int DW = $bits(rtlr_pkg::dest_entry_t);
    localparam int SW = $bits(rtlr_pkg::src_entry_t);

    function automatic logic in_table(input rtlr_pkg::id_t x);
        return CMP_W'(x) < DEPTH_C;
    endfunction

    rtlr_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    rtlr_pkg::id_t max_dest_reg;
    logic [rtlr_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic rsp_valid_reg, rsp_valid_next;
    rtlr_pkg::rsp_word_t rsp_data_reg, rsp_data_next;

    rtlr_pkg::req_word_t req_reg, req_next;
    logic ok_reg, ok_next;
    logic brk_reg, brk_next;
    logic [HOP_W-1:0] hop_reg, hop_next;
    rtlr_pkg::id_t rout_reg, rout_next;
    rtlr_pkg::id_t res_reg, res_next;
    rtlr_pkg::id_t reent_reg, reent_next;

    logic d_we, s_we;
    logic [ADDR_W-1:0] d_waddr, d_raddr, s_waddr, s_raddr;
    rtlr_pkg::dest_entry_t d_wdata, d_rdata;
    rtlr_pkg::src_entry_t s_wdata, s_rdata;

    logic req_hs, req_ok, dest_ok, hop_stop, rsp_load, show;

    rtlr_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_dest_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    rtlr_ram #(.WIDTH(SW), .DEPTH(TABLE_DEPTH)) u_src_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr == rtlr_pkg::ADDR_MAX_DEST) ?
                    rtlr_pkg::CFG_DATA_W'(max_dest_reg) : '0;

    // Range checks of an incoming word.
    assign dest_ok = (req.data.destination != '0) &&
                     (req.data.destination <= max_dest_reg) &&
                     in_table(req.data.destination);

    always_comb
    begin
        case (req.data.command)
            rtlr_pkg::CMD_STORE:      req_ok = (req.data.source != '0) && dest_ok;
            rtlr_pkg::CMD_SET_SOURCE: req_ok = (req.data.source != '0) &&
                                               in_table(req.data.source) &&
                                               (!req.data.is_looped ||
                                                in_table(req.data.feeding_destination));
            rtlr_pkg::CMD_READ:       req_ok = dest_ok;
            default:                  req_ok = 1'b0;
        endcase
    end

    assign req.ready = (state_reg == rtlr_pkg::ST_IDLE);
    assign req_hs    = req.valid && req.ready;

    // A source that is zero, outside the table or plain, or whose feed is zero or outside the table, ends the walk.
    assign hop_stop = (res_reg == '0) || !in_table(res_reg) || !s_rdata.looped ||
                      (s_rdata.feed == '0) || !in_table(s_rdata.feed);

    assign rsp_load = (state_reg == rtlr_pkg::ST_DONE) && (!rsp_valid_reg || rsp.ready);
    assign show     = ok_reg && ((req_reg.command == rtlr_pkg::CMD_STORE) ||
                                 (req_reg.command == rtlr_pkg::CMD_READ));

    assign rsp_valid_next = rsp_load || (rsp_valid_reg && !rsp.ready);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.data       = rsp_data_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rtlr_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = rtlr_pkg::ST_IDLE;
                end
            end
            rtlr_pkg::ST_IDLE:
            begin
                if (req_hs)
                begin
                    state_next = rtlr_pkg::ST_LOOKUP;
                end
            end
            rtlr_pkg::ST_LOOKUP:
            begin
                state_next = rtlr_pkg::ST_APPLY;
            end
            rtlr_pkg::ST_APPLY:
            begin
                if (ok_reg && (req_reg.command == rtlr_pkg::CMD_STORE))
                begin
                    state_next = rtlr_pkg::ST_HOP_FEED;
                end
                else
                begin
                    state_next = rtlr_pkg::ST_DONE;
                end
            end
            rtlr_pkg::ST_HOP_FEED:
            begin
                state_next = hop_stop ? rtlr_pkg::ST_FINISH : rtlr_pkg::ST_HOP_DEST;
            end
            rtlr_pkg::ST_HOP_DEST:
            begin
                state_next = (hop_reg == LAST_HOP) ? rtlr_pkg::ST_FINISH :
                                                     rtlr_pkg::ST_HOP_FEED;
            end
            rtlr_pkg::ST_FINISH:
            begin
                state_next = rtlr_pkg::ST_DONE;
            end
            rtlr_pkg::ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = rtlr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rtlr_pkg::ST_IDLE;
            end
        endcase
    end

    // RAM accesses and datapath.
    always_comb
    begin
        d_we          = 1'b0;
        s_we          = 1'b0;
        d_waddr       = ADDR_W'(req_reg.destination);
        s_waddr       = ADDR_W'(req_reg.source);
        d_wdata       = '0;
        s_wdata       = '0;
        d_raddr       = ADDR_W'(req_reg.destination);
        s_raddr       = ADDR_W'(res_reg);
        clr_addr_next = clr_addr_reg;
        cnt_next      = cnt_reg;
        req_next      = req_reg;
        ok_next       = ok_reg;
        brk_next      = brk_reg;
        hop_next      = hop_reg;
        rout_next     = rout_reg;
        res_next      = res_reg;
        reent_next    = reent_reg;
        rsp_data_next = rsp_data_reg;

        unique case (state_reg)
            rtlr_pkg::ST_CLEAR:
            begin
                d_we          = 1'b1;
                s_we          = 1'b1;
                d_waddr       = clr_addr_reg;
                s_waddr       = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            rtlr_pkg::ST_IDLE:
            begin
                if (req_hs)
                begin
                    req_next   = req.data;
                    ok_next    = req_ok;
                    brk_next   = 1'b0;
                    hop_next   = '0;
                    rout_next  = '0;
                    res_next   = '0;
                    reent_next = '0;
                end
            end
            rtlr_pkg::ST_LOOKUP:
            begin
                if (req_reg.command == rtlr_pkg::CMD_SET_SOURCE)
                begin
                    d_raddr = ADDR_W'(req_reg.feeding_destination);
                end
                s_raddr = ADDR_W'(req_reg.source);
            end
            rtlr_pkg::ST_APPLY:
            begin
                if (ok_reg)
                begin
                    case (req_reg.command)
                        rtlr_pkg::CMD_STORE:
                        begin
                            d_we       = 1'b1;
                            d_wdata    = '{routed: req_reg.source,
                                           resolved: d_rdata.resolved,
                                           reentrant: d_rdata.reentrant};
                            rout_next  = req_reg.source;
                            res_next   = req_reg.source;
                            reent_next = d_rdata.reentrant;
                            cnt_next   = cnt_reg + 1'b1;
                            s_raddr    = ADDR_W'(req_reg.source);
                        end
                        rtlr_pkg::CMD_SET_SOURCE:
                        begin
                            s_we    = 1'b1;
                            s_wdata = '{looped: req_reg.is_looped,
                                        feed: req_reg.is_looped ?
                                              req_reg.feeding_destination : s_rdata.feed};
                            if (req_reg.is_looped)
                            begin
                                d_we    = 1'b1;
                                d_waddr = ADDR_W'(req_reg.feeding_destination);
                                d_wdata = '{routed: d_rdata.routed,
                                            resolved: d_rdata.resolved,
                                            reentrant: req_reg.source};
                            end
                        end
                        default:
                        begin
                            rout_next  = d_rdata.routed;
                            res_next   = d_rdata.resolved;
                            reent_next = d_rdata.reentrant;
                        end
                    endcase
                end
            end
            rtlr_pkg::ST_HOP_FEED:
            begin
                d_raddr = ADDR_W'(s_rdata.feed);
            end
            rtlr_pkg::ST_HOP_DEST:
            begin
                res_next = d_rdata.routed;
                s_raddr  = ADDR_W'(d_rdata.routed);
                hop_next = hop_reg + 1'b1;
                if (hop_reg == LAST_HOP)
                begin
                    brk_next = 1'b1;
                end
            end
            rtlr_pkg::ST_FINISH:
            begin
                d_we    = 1'b1;
                d_wdata = '{routed: req_reg.source, resolved: res_reg, reentrant: reent_reg};
            end
            rtlr_pkg::ST_DONE:
            begin
                if (rsp_load)
                begin
                    rsp_data_next.accepted         = ok_reg;
                    rsp_data_next.routed_source    = show ? rout_reg : '0;
                    rsp_data_next.resolved_source  = show ? res_reg : '0;
                    rsp_data_next.reentrant_source = show ? reent_reg : '0;
                    rsp_data_next.loop_breakout    = brk_reg;
                    rsp_data_next.route_count      = cnt_reg;
                end
            end
            default:
            begin
                d_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtlr_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            max_dest_reg  <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (psel && penable && pwrite && pready && (paddr == rtlr_pkg::ADDR_MAX_DEST))
            begin
                max_dest_reg <= pwdata[rtlr_pkg::ID_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        ok_reg       <= ok_next;
        brk_reg      <= brk_next;
        hop_reg      <= hop_next;
        rout_reg     <= rout_next;
        res_reg      <= res_next;
        reent_reg    <= reent_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule

// File: rtl/rtlr_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the router tally loop resolver and its bind statement.
`include "router_tally_loop_resolver_assert.svh"

module rtlr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input rtlr_pkg::rsp_word_t rsp_data
);

    logic rsp_stall;
    logic rsp_reject;
    logic rsp_blank;
    logic rsp_brk;
    logic req_take;

    assign rsp_stall  = rsp_valid && !rsp_ready;
    assign rsp_reject = rsp_valid && !rsp_data.accepted;
    assign rsp_blank  = (rsp_data.routed_source == '0) && (rsp_data.resolved_source == '0) &&
                        (rsp_data.reentrant_source == '0) && !rsp_data.loop_breakout;
    assign rsp_brk    = rsp_valid && rsp_data.loop_breakout;
    assign req_take   = req_valid && req_ready;

    // A stalled response word stays offered and unchanged.
    `RTLR_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_stall, rsp_valid && $stable(rsp_data))

    // A rejected command reports no table contents.
    `RTLR_ASSERT_IMP(a_reject_zero, clk, rst_n, rsp_reject, rsp_blank)

    // A breakout only comes from an applied store.
    `RTLR_ASSERT_IMP(a_brk_accepted, clk, rst_n, rsp_brk, rsp_data.accepted)

    // The block works on one word at a time.
    `RTLR_ASSERT_NXT(a_one_at_a_time, clk, rst_n, req_take, !req_ready)

endmodule

bind router_tally_loop_resolver rtlr_checker u_rtlr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
